[src/apt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apt_pkg
// shared constants, codes and types of the allotment prefix table
// ----------------------------------------------------------------------------
package apt_pkg;

    localparam int STRIDE_BITS   = 8;
    localparam int ROUTE_ID_BITS = 16;
    localparam int LEN_BITS      = 4;
    localparam int IDX_BITS      = STRIDE_BITS + 1;
    localparam int HEAP_SIZE     = 2 ** IDX_BITS;

    // request actions
    localparam logic [1:0] ACT_MATCH  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    typedef struct packed {
        logic [ROUTE_ID_BITS-1:0] route;
        logic [LEN_BITS-1:0]      len;
    } entry_t;

    // top level to engine
    typedef struct packed {
        logic                     start;
        logic                     taken;
        logic [1:0]               action;
        logic [STRIDE_BITS-1:0]   key;
        logic [LEN_BITS-1:0]      plen;
        logic [ROUTE_ID_BITS-1:0] rid;
    } apt_req_t;

    // engine to top level
    typedef struct packed {
        logic                     idle;
        logic                     done;
        logic [1:0]               status;
        logic [ROUTE_ID_BITS-1:0] route;
    } apt_rsp_t;

endpackage
`default_nettype wire

[src/apt_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apt_engine
// entry store and sequencer: match lookup, clearing pass and subtree allotment
// ----------------------------------------------------------------------------
module apt_engine
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire apt_pkg::apt_req_t req,
    output apt_pkg::apt_rsp_t      rsp
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_M_FRINGE,
        S_M_DEFAULT,
        S_BASE,
        S_PARENT,
        S_ROOT,
        S_CHK,
        S_NEXT,
        S_DONE
    } state_t;

    localparam logic [apt_pkg::LEN_BITS-1:0] MAX_LEN =
        apt_pkg::LEN_BITS'(apt_pkg::STRIDE_BITS);
    localparam logic [apt_pkg::IDX_BITS-1:0] IDX_ONE  = apt_pkg::IDX_BITS'(1);
    localparam logic [apt_pkg::IDX_BITS-1:0] IDX_FOUR = apt_pkg::IDX_BITS'(4);
    localparam logic [apt_pkg::IDX_BITS-1:0] IDX_LAST =
        apt_pkg::IDX_BITS'(apt_pkg::HEAP_SIZE - 1);

    state_t state_reg, state_next;
    logic [apt_pkg::IDX_BITS-1:0] addr_reg, addr_next;
    logic [apt_pkg::IDX_BITS-1:0] k_reg, k_next;
    logic [apt_pkg::IDX_BITS-1:0] c_reg, c_next;
    logic [apt_pkg::IDX_BITS-1:0] clr_reg, clr_next;
    logic [1:0]                   act_reg, act_next;
    logic [apt_pkg::LEN_BITS-1:0] plen_reg, plen_next;
    logic [apt_pkg::ROUTE_ID_BITS-1:0] rid_reg, rid_next;
    apt_pkg::entry_t old_reg, old_next;
    apt_pkg::entry_t new_reg, new_next;
    logic [1:0] status_reg, status_next;
    logic [apt_pkg::ROUTE_ID_BITS-1:0] result_reg, result_next;

    // entry store
    apt_pkg::entry_t mem [apt_pkg::HEAP_SIZE];
    apt_pkg::entry_t rdata_reg;
    logic                         mem_we;
    logic [apt_pkg::IDX_BITS-1:0] mem_waddr;
    apt_pkg::entry_t              mem_wdata;

    logic [apt_pkg::LEN_BITS-1:0] shamt;
    logic [apt_pkg::IDX_BITS-1:0] base_idx;
    logic                         present;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[addr_next];
    end

    // base index of the incoming prefix
    assign shamt    = MAX_LEN - req.plen;
    assign base_idx = (apt_pkg::IDX_BITS'(req.key) >> shamt) + (IDX_ONE << req.plen);
    assign present  = (rdata_reg.route != '0) && (rdata_reg.len == plen_reg);

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        k_next      = k_reg;
        c_next      = c_reg;
        clr_next    = clr_reg;
        act_next    = act_reg;
        plen_next   = plen_reg;
        rid_next    = rid_reg;
        old_next    = old_reg;
        new_next    = new_reg;
        status_next = status_reg;
        result_next = result_reg;
        mem_we      = 1'b0;
        mem_waddr   = c_reg;
        mem_wdata   = new_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + IDX_ONE;
                if (clr_reg == IDX_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.start)
                begin
                    act_next    = req.action;
                    plen_next   = req.plen;
                    rid_next    = req.rid;
                    status_next = apt_pkg::ST_INVALID;
                    result_next = '0;
                    if (req.action == apt_pkg::ACT_MATCH)
                    begin
                        addr_next  = {1'b1, req.key};
                        state_next = S_M_FRINGE;
                    end
                    else if (((req.action == apt_pkg::ACT_INSERT && req.rid != '0)
                              || req.action == apt_pkg::ACT_DELETE)
                             && req.plen <= MAX_LEN)
                    begin
                        addr_next  = base_idx;
                        k_next     = base_idx;
                        state_next = S_BASE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_M_FRINGE:
            begin
                if (rdata_reg.route != '0)
                begin
                    status_next = apt_pkg::ST_OK;
                    result_next = rdata_reg.route;
                    state_next  = S_DONE;
                end
                else
                begin
                    addr_next  = IDX_ONE;
                    state_next = S_M_DEFAULT;
                end
            end
            S_M_DEFAULT:
            begin
                result_next = rdata_reg.route;
                status_next = (rdata_reg.route != '0) ? apt_pkg::ST_OK
                                                      : apt_pkg::ST_NOT_FOUND;
                state_next  = S_DONE;
            end
            S_BASE:
            begin
                old_next = rdata_reg;
                if (act_reg == apt_pkg::ACT_INSERT)
                begin
                    if (present)
                    begin
                        status_next = apt_pkg::ST_DUPLICATE;
                        result_next = rdata_reg.route;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        new_next.route = rid_reg;
                        new_next.len   = plen_reg;
                        status_next    = apt_pkg::ST_OK;
                        result_next    = rid_reg;
                        state_next     = S_ROOT;
                    end
                end
                else
                begin
                    if (!present)
                    begin
                        status_next = apt_pkg::ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        status_next = apt_pkg::ST_OK;
                        result_next = rdata_reg.route;
                        if (k_reg >= IDX_FOUR)
                        begin
                            addr_next  = k_reg >> 1;
                            state_next = S_PARENT;
                        end
                        else
                        begin
                            new_next   = '0;
                            state_next = S_ROOT;
                        end
                    end
                end
            end
            S_PARENT:
            begin
                new_next   = rdata_reg;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                mem_we    = 1'b1;
                mem_waddr = k_reg;
                if (k_reg == IDX_ONE || k_reg[apt_pkg::IDX_BITS-1])
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    c_next     = {k_reg[apt_pkg::IDX_BITS-2:0], 1'b0};
                    addr_next  = {k_reg[apt_pkg::IDX_BITS-2:0], 1'b0};
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                // replace a copy of the old occupant, descend below it
                if (rdata_reg == old_reg)
                begin
                    mem_we = 1'b1;
                    if (!c_reg[apt_pkg::IDX_BITS-1])
                    begin
                        c_next    = {c_reg[apt_pkg::IDX_BITS-2:0], 1'b0};
                        addr_next = {c_reg[apt_pkg::IDX_BITS-2:0], 1'b0};
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (!c_reg[0])
                begin
                    c_next     = c_reg + IDX_ONE;
                    addr_next  = c_reg + IDX_ONE;
                    state_next = S_CHK;
                end
                else if ((c_reg >> 1) == k_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    c_next = c_reg >> 1;
                end
            end
            S_DONE:
            begin
                if (req.taken)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            addr_reg   <= '0;
            k_reg      <= '0;
            c_reg      <= '0;
            clr_reg    <= '0;
            act_reg    <= apt_pkg::ACT_MATCH;
            plen_reg   <= '0;
            rid_reg    <= '0;
            old_reg    <= '0;
            new_reg    <= '0;
            status_reg <= apt_pkg::ST_OK;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            k_reg      <= k_next;
            c_reg      <= c_next;
            clr_reg    <= clr_next;
            act_reg    <= act_next;
            plen_reg   <= plen_next;
            rid_reg    <= rid_next;
            old_reg    <= old_next;
            new_reg    <= new_next;
            status_reg <= status_next;
            result_reg <= result_next;
        end
    end

    assign rsp.idle   = (state_reg == S_IDLE);
    assign rsp.done   = (state_reg == S_DONE);
    assign rsp.status = status_reg;
    assign rsp.route  = result_reg;

endmodule
`default_nettype wire

[src/allotment_prefix_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// allotment_prefix_table
// one level of an allotment routing table with longest prefix match
// ----------------------------------------------------------------------------
//  channel   signals                                       handshake
//  request   action, key, prefix_length, route_id          request_valid / request_stall
//  result    status, result_route                          result_valid / result_stall
//
//  match: reads the fringe entry, then the default entry if the fringe entry is empty
//  insert or delete at the default or a fringe index: writes only the base entry
//  interior insert or delete: also walks the subtree below the base entry
//  after reset a clearing pass over all 2^(STRIDE_BITS+1) entries holds request_stall high
//  one request at a time, the next taken in the cycle after the result leaves the engine
//  a held result keeps the engine from taking the next
// ----------------------------------------------------------------------------
module allotment_prefix_table
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              request_valid,
    output logic                                   request_stall,
    input  wire logic [1:0]                        action,
    input  wire logic [apt_pkg::STRIDE_BITS-1:0]   key,
    input  wire logic [apt_pkg::LEN_BITS-1:0]      prefix_length,
    input  wire logic [apt_pkg::ROUTE_ID_BITS-1:0] route_id,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output logic [1:0]                             status,
    output logic [apt_pkg::ROUTE_ID_BITS-1:0]      result_route
);

    apt_pkg::apt_req_t eng_req;
    apt_pkg::apt_rsp_t eng_rsp;

    logic                              out_valid_reg, out_valid_next;
    logic [1:0]                        status_reg, status_next;
    logic [apt_pkg::ROUTE_ID_BITS-1:0] route_reg, route_next;
    logic                              slot_free;

    // output slot can take a result when empty or being drained this cycle
    assign slot_free = !out_valid_reg || !result_stall;

    // engine is only ready while idle
    assign request_stall = !eng_rsp.idle;

    assign eng_req.start  = request_valid && eng_rsp.idle;
    assign eng_req.taken  = eng_rsp.done && slot_free;
    assign eng_req.action = action;
    assign eng_req.key    = key;
    assign eng_req.plen   = prefix_length;
    assign eng_req.rid    = route_id;

    apt_engine u_engine
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (eng_req),
        .rsp   (eng_rsp)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        route_next     = route_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (eng_req.taken)
        begin
            out_valid_next = 1'b1;
            status_next    = eng_rsp.status;
            route_next     = eng_rsp.route;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= apt_pkg::ST_OK;
            route_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            route_reg     <= route_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign result_route = route_reg;

endmodule
`default_nettype wire

[src/apt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apt_checker
// port level checks of the allotment prefix table
// ----------------------------------------------------------------------------
module apt_checker
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              request_valid,
    input wire logic                              request_stall,
    input wire logic                              result_valid,
    input wire logic                              result_stall,
    input wire logic [1:0]                        status,
    input wire logic [apt_pkg::ROUTE_ID_BITS-1:0] result_route
);

    // a request keeps the block busy in the following cycle
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && !request_stall |=> request_stall)
        else $error("request taken while previous one in flight");

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(status) && $stable(result_route))
        else $error("stalled result changed");

    // failures carry no route
    a_fail_no_route: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == apt_pkg::ST_NOT_FOUND || status == apt_pkg::ST_INVALID)
            |-> result_route == '0)
        else $error("failed request reports a route");

    // success always names a route
    a_ok_route: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == apt_pkg::ST_OK || status == apt_pkg::ST_DUPLICATE)
            |-> result_route != '0)
        else $error("successful request reports no route");

endmodule

bind allotment_prefix_table apt_checker u_apt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .result_route  (result_route)
);
`default_nettype wire

[tb/sv/tb_allotment_prefix_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_allotment_prefix_table
// self-checking bench for the allotment prefix table: a queue-fed driver
// issues match, insert and delete requests, a shadow heap predicts every
// result and a monitor compares status and route in order, under several
// idle and stall phases
// ----------------------------------------------------------------------------
module tb_allotment_prefix_table;

    import apt_pkg::*;

    // one request as the driver presents it
    typedef struct {
        logic [1:0]               act;
        logic [STRIDE_BITS-1:0]   key;
        logic [LEN_BITS-1:0]      plen;
        logic [ROUTE_ID_BITS-1:0] rid;
    } request_t;

    // one predicted result
    typedef struct {
        logic [1:0]               status;
        logic [ROUTE_ID_BITS-1:0] route;
    } outcome_t;

    // a prefix the stimulus has installed, kept so deletes and matches hit it
    typedef struct {
        logic [STRIDE_BITS-1:0] key;
        logic [LEN_BITS-1:0]    plen;
    } prefix_t;

    // action code with no meaning
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    localparam int FRINGE_BASE = 2 ** STRIDE_BITS;
    localparam int ITEMS_PER_PHASE = 290;
    // an interior allotment walks the subtree below its base index
    localparam int SETTLE_CYCLES = 4 * HEAP_SIZE;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     request_valid = 1'b0;
    logic                     request_stall;
    logic [1:0]               action = ACT_MATCH;
    logic [STRIDE_BITS-1:0]   key = '0;
    logic [LEN_BITS-1:0]      prefix_length = '0;
    logic [ROUTE_ID_BITS-1:0] route_id = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic [1:0]               status;
    logic [ROUTE_ID_BITS-1:0] result_route;

    request_t request_queue[$];
    outcome_t awaited_results[$];
    prefix_t  installed_prefixes[$];

    // shadow of the entry store and the route count
    entry_t               heap[HEAP_SIZE];
    logic [9:0]           installed_count;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count = 0;

    allotment_prefix_table u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .action        (action),
        .key           (key),
        .prefix_length (prefix_length),
        .route_id      (route_id),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .result_route  (result_route)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // shadow heap
    // ------------------------------------------------------------------------

    // replace the old entry over the subtree under a non-fringe index,
    // stopping wherever a more specific entry breaks the chain; all tests
    // are made on the contents before any write, as the allotment does
    function automatic void spread(int unsigned top, entry_t old_e, entry_t new_e);
        logic [HEAP_SIZE-1:0] hit;
        hit = '0;
        hit[top] = 1'b1;
        for (int unsigned n = 2 * top; n < HEAP_SIZE; n++)
        begin
            if (hit[n >> 1] && heap[n] == old_e)
                hit[n] = 1'b1;
        end
        for (int unsigned n = top; n < HEAP_SIZE; n++)
        begin
            if (hit[n])
                heap[n] = new_e;
        end
    endfunction

    // predict the result of one request and update the shadow state
    function automatic outcome_t apply_request(request_t rq);
        outcome_t    res;
        int unsigned base;
        int unsigned fringe;
        entry_t      prev;
        entry_t      next;
        entry_t      fresh;
        logic        present;
        res.status = ST_INVALID;
        res.route  = '0;
        if (rq.act == ACT_MATCH)
        begin
            // fringe entry first, then the default route at index 1
            fringe = rq.key + FRINGE_BASE;
            res.route = (heap[fringe].route != '0) ? heap[fringe].route : heap[1].route;
            res.status = (res.route != '0) ? ST_OK : ST_NOT_FOUND;
        end
        else if ((rq.act == ACT_INSERT || rq.act == ACT_DELETE) && rq.plen <= STRIDE_BITS)
        begin
            base = (rq.key >> (STRIDE_BITS - rq.plen)) + (1 << rq.plen);
            prev = heap[base];
            present = (prev.route != '0) && (prev.len == rq.plen);
            if (rq.act == ACT_INSERT)
            begin
                if (rq.rid == '0)
                begin
                    res.status = ST_INVALID;
                end
                else if (present)
                begin
                    res.status = ST_DUPLICATE;
                    res.route  = prev.route;
                end
                else
                begin
                    fresh.route = rq.rid;
                    fresh.len   = rq.plen;
                    if (base == 1 || base >= FRINGE_BASE)
                        heap[base] = fresh;
                    else
                        spread(base, prev, fresh);
                    installed_count = installed_count + 1'b1;
                    res.status = ST_OK;
                    res.route  = rq.rid;
                end
            end
            else
            begin
                if (!present)
                begin
                    res.status = ST_NOT_FOUND;
                end
                else
                begin
                    // the children of index 1 fall back to no route at all
                    next = '0;
                    if ((base >> 1) > 1)
                        next = heap[base >> 1];
                    if (base == 1 || base >= FRINGE_BASE)
                        heap[base] = next;
                    else
                        spread(base, prev, next);
                    installed_count = installed_count - 1'b1;
                    res.status = ST_OK;
                    res.route  = prev.route;
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // driver: predicts on acceptance, then loads the next request or idles
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_proc
        request_t rq;
        request_t nxt;
        if (!rst_n)
        begin
            request_valid <= 1'b0;
        end
        else
        begin
            if (request_valid && !request_stall)
            begin
                rq.act  = action;
                rq.key  = key;
                rq.plen = prefix_length;
                rq.rid  = route_id;
                awaited_results.push_back(apply_request(rq));
            end
            // a stalled request holds its payload untouched
            if (!request_valid || !request_stall)
            begin
                if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = request_queue.pop_front();
                    request_valid <= 1'b1;
                    action        <= nxt.act;
                    key           <= nxt.key;
                    prefix_length <= nxt.plen;
                    route_id      <= nxt.rid;
                end
                else
                begin
                    request_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compares each accepted result with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_proc
        outcome_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with no request outstanding: status %0d route %h",
                             $time, status, result_route);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                    begin
                        error_count++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, status);
                    end
                    if (result_route !== want.route)
                    begin
                        error_count++;
                        $display("%0t: result_route mismatch: expected %h, actual %h",
                                 $time, want.route, result_route);
                    end
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic queue_request(logic [1:0] act, logic [STRIDE_BITS-1:0] k,
                                 logic [LEN_BITS-1:0] pl, logic [ROUTE_ID_BITS-1:0] rid);
        request_t rq;
        rq.act  = act;
        rq.key  = k;
        rq.plen = pl;
        rq.rid  = rid;
        request_queue.push_back(rq);
    endtask

    // mostly long prefixes so that subtree walks stay short
    function automatic logic [LEN_BITS-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return LEN_BITS'($urandom_range(STRIDE_BITS, 5));
        else if (roll < 95)
            return LEN_BITS'($urandom_range(4, 1));
        return '0;
    endfunction

    task automatic queue_random_request();
        prefix_t     pf;
        int unsigned roll;
        int unsigned pick;
        logic [STRIDE_BITS-1:0] k;
        logic [LEN_BITS-1:0]    pl;
        logic [STRIDE_BITS-1:0] noise;
        roll = $urandom_range(99);
        k = STRIDE_BITS'($urandom);
        if (roll < 35)
        begin
            // match, often inside a known prefix; length and id are noise
            if (installed_prefixes.size() > 0 && $urandom_range(1) == 1)
            begin
                pf = installed_prefixes[$urandom_range(installed_prefixes.size() - 1)];
                noise = STRIDE_BITS'($urandom);
                k = (pf.plen == 0) ? noise
                  : ((pf.key & ~(8'hFF >> pf.plen)) | (noise & (8'hFF >> pf.plen)));
            end
            queue_request(ACT_MATCH, k, LEN_BITS'($urandom), ROUTE_ID_BITS'($urandom));
        end
        else if (roll < 75)
        begin
            // insert, sometimes repeating a known prefix to get a duplicate
            if (installed_prefixes.size() > 0 && $urandom_range(9) == 0)
            begin
                pf = installed_prefixes[$urandom_range(installed_prefixes.size() - 1)];
                k  = pf.key;
                pl = pf.plen;
            end
            else
            begin
                pl = pick_length();
                pf.key  = k;
                pf.plen = pl;
                if (installed_prefixes.size() < 64)
                    installed_prefixes.push_back(pf);
            end
            queue_request(ACT_INSERT, k, pl, ROUTE_ID_BITS'($urandom_range(16'hFFFF, 1)));
        end
        else if (roll < 97)
        begin
            // delete, mostly of a prefix put in earlier
            if (installed_prefixes.size() > 0 && $urandom_range(9) < 7)
            begin
                pick = $urandom_range(installed_prefixes.size() - 1);
                pf = installed_prefixes[pick];
                installed_prefixes.delete(pick);
                k  = pf.key;
                pl = pf.plen;
            end
            else
            begin
                pl = pick_length();
            end
            queue_request(ACT_DELETE, k, pl, ROUTE_ID_BITS'($urandom));
        end
        else
        begin
            // malformed: unknown action, overlong prefix or zero id
            case ($urandom_range(2))
                0: queue_request(ACT_RESERVED, k, LEN_BITS'($urandom),
                                 ROUTE_ID_BITS'($urandom));
                1: queue_request($urandom_range(1) ? ACT_INSERT : ACT_DELETE, k,
                                 LEN_BITS'($urandom_range(15, STRIDE_BITS + 1)),
                                 ROUTE_ID_BITS'($urandom));
                default: queue_request(ACT_INSERT, k, pick_length(), '0);
            endcase
        end
    endtask

    task automatic drain();
        while (request_queue.size() > 0 || request_valid || awaited_results.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus_proc
        for (int unsigned n = 0; n < HEAP_SIZE; n++)
            heap[n] = '0;
        installed_count = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, no idling
        queue_request(ACT_MATCH,  8'hFF, 4'd0, 16'h0000);   // empty table
        queue_request(ACT_INSERT, 8'h12, 4'd4, 16'h0000);   // zero id
        queue_request(ACT_INSERT, 8'h12, 4'd9, 16'h1234);   // length too long
        queue_request(ACT_INSERT, 8'h12, 4'd15, 16'hFFFF);
        queue_request(ACT_DELETE, 8'h34, 4'd12, 16'h0000);
        queue_request(ACT_RESERVED, 8'hFF, 4'd15, 16'hFFFF); // unknown action
        queue_request(ACT_DELETE, 8'h40, 4'd2, 16'h0000);   // absent prefix
        queue_request(ACT_INSERT, 8'h00, 4'd0, 16'hFFFF);   // default route
        queue_request(ACT_MATCH,  8'h00, 4'd15, 16'hFFFF);  // length and id ignored
        queue_request(ACT_INSERT, 8'h5A, 4'd0, 16'h1111);   // duplicate default
        queue_request(ACT_INSERT, 8'h80, 4'd1, 16'h0001);   // widest interior allotment
        queue_request(ACT_INSERT, 8'hA5, 4'd8, 16'hAAAA);   // fringe entry
        queue_request(ACT_INSERT, 8'hA0, 4'd4, 16'h5555);   // stops at the fringe route
        queue_request(ACT_MATCH,  8'hA5, 4'd0, 16'h0000);
        queue_request(ACT_MATCH,  8'hA1, 4'd0, 16'h0000);
        queue_request(ACT_MATCH,  8'h7F, 4'd0, 16'h0000);   // falls back to default
        queue_request(ACT_DELETE, 8'hAF, 4'd4, 16'hFFFF);   // parent route comes back
        queue_request(ACT_DELETE, 8'hA0, 4'd4, 16'h0000);   // entry now of another length
        queue_request(ACT_MATCH,  8'hA1, 4'd0, 16'h0000);
        queue_request(ACT_DELETE, 8'hFF, 4'd1, 16'h0000);   // child of the root, no route
        queue_request(ACT_DELETE, 8'hA5, 4'd8, 16'h0000);
        queue_request(ACT_DELETE, 8'h00, 4'd0, 16'h0000);
        queue_request(ACT_MATCH,  8'hA5, 4'd0, 16'h0000);
        queue_request(ACT_INSERT, 8'hFF, 4'd8, 16'h8000);
        drain();

        // random phases: free running, sender idle, receiver stalling, both
        for (int unsigned phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++)
                queue_random_request();
            drain();
        end

        // anything arriving now has no request behind it
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_allotment_prefix_table: done, clean");
        else
            $display("tb_allotment_prefix_table: done, errors");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #60_000_000;
        $display("tb_allotment_prefix_table: done, errors");
        $finish;
    end

endmodule

[sim.f]
src/apt_pkg.sv
src/apt_engine.sv
src/allotment_prefix_table.sv
src/apt_checker.sv
tb/sv/tb_allotment_prefix_table.sv
